>>> sv/xpdfr_pkg.sv
// ----------------------------------------------------------------------------
// xpdfr_pkg
// Types, codes and the microprogram of the packet deframer.
// ----------------------------------------------------------------------------
package xpdfr_pkg;

  // payload of one input transfer
  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_item_t;

  // payload of one result transfer
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [1:0] error_code;
    logic       last;
  } out_item_t;

  // configuration register values
  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] stop_byte;
    logic [7:0] timeout_ticks;
  } cfg_t;

  // item kinds
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_LENGTH  = 2'd0;
  localparam logic [1:0] ERR_TIMEOUT = 2'd1;
  localparam logic [1:0] ERR_STOP    = 2'd2;
  localparam logic [1:0] ERR_PARITY  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_START   = 2'd0;
  localparam logic [1:0] CFG_STOP    = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  // receiver phase
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_IS_TICK,
    C_PH_HUNT,
    C_PH_LEN,
    C_LEN_BAD,
    C_BODY_MORE,
    C_STOP_BAD,
    C_PARITY_BAD,
    C_TIMEOUT,
    C_EMIT_MORE
  } cond_t;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_HUNT,
    OP_LEN_LOAD,
    OP_BODY_WR,
    OP_WAIT_INC,
    OP_TO_HUNT,
    OP_EMIT_INIT,
    OP_EMIT_NEXT
  } op_t;

  // result emission
  typedef enum logic [1:0] {
    EM_NONE,
    EM_ERROR,
    EM_DATA
  } emit_t;

  typedef logic [4:0] step_t;

  // one control word
  typedef struct packed {
    logic       ready;
    cond_t      cond;
    step_t      target;
    op_t        op;
    emit_t      emit;
    logic [1:0] err;
  } ucode_t;

  // status flags from the datapath
  typedef struct packed {
    logic is_tick;
    logic ph_hunt;
    logic ph_len;
    logic len_bad;
    logic body_more;
    logic stop_bad;
    logic parity_bad;
    logic timeout;
    logic emit_more;
  } dp_flags_t;

  // program entry points
  localparam step_t S_FETCH     = 5'd0;
  localparam step_t S_EMIT_RD   = 5'd8;
  localparam step_t S_TICK      = 5'd11;
  localparam step_t S_HUNT      = 5'd14;
  localparam step_t S_LEN       = 5'd15;
  localparam step_t S_E_LENGTH  = 5'd17;
  localparam step_t S_E_TIMEOUT = 5'd18;
  localparam step_t S_E_STOP    = 5'd19;
  localparam step_t S_E_PARITY  = 5'd20;

  // microprogram rom
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    w = '{ready: 1'b0, cond: C_NEVER, target: S_FETCH, op: OP_NOP,
          emit: EM_NONE, err: ERR_LENGTH};
    case (step)
      // wait for an input transfer
      5'd0: begin
        w.ready = 1'b1; w.cond = C_NO_INPUT; w.target = S_FETCH;
      end
      // dispatch on item kind and phase
      5'd1: begin w.cond = C_IS_TICK; w.target = S_TICK; end
      5'd2: begin w.cond = C_PH_HUNT; w.target = S_HUNT; end
      5'd3: begin w.cond = C_PH_LEN;  w.target = S_LEN;  end
      // body byte
      5'd4: begin
        w.op = OP_BODY_WR; w.cond = C_BODY_MORE; w.target = S_FETCH;
      end
      5'd5: begin w.cond = C_STOP_BAD;   w.target = S_E_STOP;   end
      5'd6: begin w.cond = C_PARITY_BAD; w.target = S_E_PARITY; end
      // good frame readout
      5'd7: begin w.op = OP_EMIT_INIT; end
      5'd8: begin w.op = OP_NOP; end
      5'd9: begin
        w.emit = EM_DATA; w.op = OP_EMIT_NEXT;
        w.cond = C_EMIT_MORE; w.target = S_EMIT_RD;
      end
      5'd10: begin w.op = OP_TO_HUNT; w.cond = C_ALWAYS; w.target = S_FETCH; end
      // tick
      5'd11: begin w.cond = C_PH_HUNT; w.target = S_FETCH; end
      5'd12: begin w.cond = C_TIMEOUT; w.target = S_E_TIMEOUT; end
      5'd13: begin w.op = OP_WAIT_INC; w.cond = C_ALWAYS; w.target = S_FETCH; end
      // start byte hunt
      5'd14: begin w.op = OP_HUNT; w.cond = C_ALWAYS; w.target = S_FETCH; end
      // length byte
      5'd15: begin w.cond = C_LEN_BAD; w.target = S_E_LENGTH; end
      5'd16: begin w.op = OP_LEN_LOAD; w.cond = C_ALWAYS; w.target = S_FETCH; end
      // error reports
      5'd17: begin
        w.emit = EM_ERROR; w.err = ERR_LENGTH; w.op = OP_TO_HUNT;
        w.cond = C_ALWAYS; w.target = S_FETCH;
      end
      5'd18: begin
        w.emit = EM_ERROR; w.err = ERR_TIMEOUT; w.op = OP_TO_HUNT;
        w.cond = C_ALWAYS; w.target = S_FETCH;
      end
      5'd19: begin
        w.emit = EM_ERROR; w.err = ERR_STOP; w.op = OP_TO_HUNT;
        w.cond = C_ALWAYS; w.target = S_FETCH;
      end
      5'd20: begin
        w.emit = EM_ERROR; w.err = ERR_PARITY; w.op = OP_TO_HUNT;
        w.cond = C_ALWAYS; w.target = S_FETCH;
      end
      default: begin w.cond = C_ALWAYS; w.target = S_FETCH; end
    endcase
    return w;
  endfunction

endpackage

>>> sv/xpdfr_ram.sv
// ----------------------------------------------------------------------------
// xpdfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module xpdfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/xpdfr_useq.sv
// ----------------------------------------------------------------------------
// xpdfr_useq
// Microprogram sequencer: step counter, control rom and conditional jumps.
// ----------------------------------------------------------------------------
module xpdfr_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_free,
  input  xpdfr_pkg::dp_flags_t flags,
  output xpdfr_pkg::ucode_t   ctrl
);

  xpdfr_pkg::step_t  step_r;
  xpdfr_pkg::step_t  step_nxt;
  xpdfr_pkg::ucode_t uw;
  logic              hold;
  logic              take;

  assign uw = xpdfr_pkg::ucode_rom(step_r);

  // an emitting step waits for room in the output register
  assign hold = (uw.emit != xpdfr_pkg::EM_NONE) && !out_free;

  // condition select
  always_comb begin
    case (uw.cond)
      xpdfr_pkg::C_NEVER:      take = 1'b0;
      xpdfr_pkg::C_ALWAYS:     take = 1'b1;
      xpdfr_pkg::C_NO_INPUT:   take = !in_valid;
      xpdfr_pkg::C_IS_TICK:    take = flags.is_tick;
      xpdfr_pkg::C_PH_HUNT:    take = flags.ph_hunt;
      xpdfr_pkg::C_PH_LEN:     take = flags.ph_len;
      xpdfr_pkg::C_LEN_BAD:    take = flags.len_bad;
      xpdfr_pkg::C_BODY_MORE:  take = flags.body_more;
      xpdfr_pkg::C_STOP_BAD:   take = flags.stop_bad;
      xpdfr_pkg::C_PARITY_BAD: take = flags.parity_bad;
      xpdfr_pkg::C_TIMEOUT:    take = flags.timeout;
      xpdfr_pkg::C_EMIT_MORE:  take = flags.emit_more;
      default:                 take = 1'b1;
    endcase
  end

  // next step
  always_comb begin
    if (hold) begin
      step_nxt = step_r;
    end else if (take) begin
      step_nxt = uw.target;
    end else begin
      step_nxt = step_r + 5'd1;
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= xpdfr_pkg::S_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

  // suppress side effects of a held step
  always_comb begin
    ctrl = uw;
    if (hold) begin
      ctrl.op   = xpdfr_pkg::OP_NOP;
      ctrl.emit = xpdfr_pkg::EM_NONE;
    end
  end

endmodule

>>> sv/xpdfr_dpath.sv
// ----------------------------------------------------------------------------
// xpdfr_dpath
// Frame datapath: item register, frame state, body buffer and result build.
// ----------------------------------------------------------------------------
module xpdfr_dpath #(
  parameter int FRAME_BUFFER = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  xpdfr_pkg::ucode_t     ctrl,
  input  logic                  in_take,
  input  xpdfr_pkg::in_item_t   in_data,
  input  xpdfr_pkg::cfg_t       cfg,
  output xpdfr_pkg::dp_flags_t  flags,
  output xpdfr_pkg::out_item_t  result
);

  localparam int         AW      = $clog2(FRAME_BUFFER);
  localparam logic [8:0] MAX_LEN = 9'(FRAME_BUFFER - 2);

  xpdfr_pkg::in_item_t item_r;
  xpdfr_pkg::phase_t   phase_r, phase_nxt;
  logic [7:0]          len_r, len_nxt;
  logic [7:0]          idx_r, idx_nxt;
  logic [7:0]          par_r, par_nxt;
  logic [7:0]          wait_r, wait_nxt;
  logic [7:0]          pbyte_r, pbyte_nxt;
  logic [7:0]          cnt_r, cnt_nxt;
  logic                ram_we;
  logic [7:0]          ram_rdata;
  logic [7:0]          b;

  assign b = item_r.rx_byte;

  // body buffer
  xpdfr_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BUFFER)
  ) u_body (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r[AW-1:0]),
    .wdata (b),
    .raddr (cnt_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // status flags
  always_comb begin
    flags.is_tick    = (item_r.func == xpdfr_pkg::FUNC_TICK);
    flags.ph_hunt    = (phase_r != xpdfr_pkg::PH_LEN) && (phase_r != xpdfr_pkg::PH_BODY);
    flags.ph_len     = (phase_r == xpdfr_pkg::PH_LEN);
    flags.len_bad    = (b < 8'd3) || ({1'b0, b} > MAX_LEN);
    flags.body_more  = ({1'b0, idx_r} + 9'd1) < {1'b0, len_r};
    flags.stop_bad   = (b != cfg.stop_byte);
    flags.parity_bad = (pbyte_r != par_r);
    flags.timeout    = ({1'b0, wait_r} + 9'd1) >= {1'b0, cfg.timeout_ticks};
    flags.emit_more  = ({1'b0, cnt_r} + 9'd3) < {1'b0, len_r};
  end

  // datapath operations
  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    par_nxt   = par_r;
    wait_nxt  = wait_r;
    pbyte_nxt = pbyte_r;
    cnt_nxt   = cnt_r;
    ram_we    = 1'b0;
    case (ctrl.op)
      xpdfr_pkg::OP_NOP: begin
      end
      xpdfr_pkg::OP_HUNT: begin
        if (b == cfg.start_byte) begin
          phase_nxt = xpdfr_pkg::PH_LEN;
          wait_nxt  = 8'd0;
        end
      end
      xpdfr_pkg::OP_LEN_LOAD: begin
        len_nxt   = b;
        par_nxt   = b;
        idx_nxt   = 8'd0;
        wait_nxt  = 8'd0;
        phase_nxt = xpdfr_pkg::PH_BODY;
      end
      xpdfr_pkg::OP_BODY_WR: begin
        ram_we   = 1'b1;
        wait_nxt = 8'd0;
        idx_nxt  = idx_r + 8'd1;
        // command and data bytes feed the parity, the parity byte is kept
        if (({1'b0, idx_r} + 9'd2) < {1'b0, len_r}) begin
          par_nxt = par_r ^ b;
        end
        if (({1'b0, idx_r} + 9'd2) == {1'b0, len_r}) begin
          pbyte_nxt = b;
        end
      end
      xpdfr_pkg::OP_WAIT_INC: begin
        wait_nxt = wait_r + 8'd1;
      end
      xpdfr_pkg::OP_TO_HUNT: begin
        phase_nxt = xpdfr_pkg::PH_HUNT;
        idx_nxt   = 8'd0;
        wait_nxt  = 8'd0;
      end
      xpdfr_pkg::OP_EMIT_INIT: begin
        cnt_nxt = 8'd0;
      end
      xpdfr_pkg::OP_EMIT_NEXT: begin
        cnt_nxt = cnt_r + 8'd1;
      end
      default: begin
      end
    endcase
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= xpdfr_pkg::PH_HUNT;
      len_r   <= 8'd0;
      idx_r   <= 8'd0;
      par_r   <= 8'd0;
      wait_r  <= 8'd0;
      cnt_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
      par_r   <= par_nxt;
      wait_r  <= wait_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pbyte_r <= pbyte_nxt;
    if (in_take) begin
      item_r <= in_data;
    end
  end

  // result payload
  always_comb begin
    if (ctrl.emit == xpdfr_pkg::EM_DATA) begin
      result.kind       = (cnt_r == 8'd0) ? xpdfr_pkg::KIND_CMD : xpdfr_pkg::KIND_DATA;
      result.byte_value = ram_rdata;
      result.error_code = xpdfr_pkg::ERR_LENGTH;
      result.last       = !flags.emit_more;
    end else begin
      result.kind       = xpdfr_pkg::KIND_ERR;
      result.byte_value = 8'd0;
      result.error_code = ctrl.err;
      result.last       = 1'b1;
    end
  end

endmodule

>>> sv/xor_parity_packet_deframer_unit.sv
// ----------------------------------------------------------------------------
// xor_parity_packet_deframer_unit
// Start/length/XOR-parity/stop packet deframer, microprogram controlled.
// ----------------------------------------------------------------------------
// Input channel (in_valid, in_stall, in_data): each transfer is a received
// byte or a one millisecond tick. Result channel (out_valid, out_stall,
// out_data): command and data bytes of good frames and error reports, the
// final result of each input item marked with last.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (start byte,
// stop byte, timeout ticks); the user must do so only while the block is idle,
// which the block itself does not enforce.
// Items are taken one at a time: input stays stalled while the microprogram
// runs the steps for the last item. After the stop byte of a good frame the
// program reads the command and data bytes out of the body buffer, whose read
// data is registered, and emits them in order.
// Results leave through one output register; a stall on the result channel
// holds the emitting step, so input stays stalled until the result moves on.
// Reset (rst_n low, synchronous) returns the program to its fetch step,
// the frame state to hunting and the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module xor_parity_packet_deframer_unit #(
  parameter int FRAME_BUFFER = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  xpdfr_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output xpdfr_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_addr,
  input  logic [7:0]           cfg_wdata
);

  xpdfr_pkg::cfg_t      cfg_r;
  xpdfr_pkg::ucode_t    ctrl;
  xpdfr_pkg::dp_flags_t flags;
  xpdfr_pkg::out_item_t result;
  xpdfr_pkg::out_item_t out_data_r;
  logic                 out_valid_r;
  logic                 out_free;
  logic                 in_take;
  logic                 out_load;

  assign in_stall = !ctrl.ready;
  assign in_take  = in_valid && ctrl.ready;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (ctrl.emit != xpdfr_pkg::EM_NONE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte    <= 8'd0;
      cfg_r.stop_byte     <= 8'd255;
      cfg_r.timeout_ticks <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_addr)
        xpdfr_pkg::CFG_START:   cfg_r.start_byte    <= cfg_wdata;
        xpdfr_pkg::CFG_STOP:    cfg_r.stop_byte     <= cfg_wdata;
        xpdfr_pkg::CFG_TIMEOUT: cfg_r.timeout_ticks <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  xpdfr_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .flags    (flags),
    .ctrl     (ctrl)
  );

  // datapath
  xpdfr_dpath #(
    .FRAME_BUFFER (FRAME_BUFFER)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .in_take (in_take),
    .in_data (in_data),
    .cfg     (cfg_r),
    .flags   (flags),
    .result  (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // a result is never loaded over one still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(out_valid_r && out_stall))
    else $error("result loaded into a full output register");

  // in the cycle after an input transfer the program is busy and input is stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_stall)
    else $error("input taken on two consecutive cycles");

  // an error report is always the final result and carries no byte
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.kind == xpdfr_pkg::KIND_ERR)
      |-> (out_data_r.last && out_data_r.byte_value == 8'd0))
    else $error("malformed error report");
`endif

endmodule

>>> test/tb_xor_parity_packet_deframer_unit.sv
// ----------------------------------------------------------------------------
// tb_xor_parity_packet_deframer_unit
// Self-checking bench for the start/length/parity/stop packet deframer.
// ----------------------------------------------------------------------------
// Bytes and ticks go in through the input channel. A frame tracker mirrors
// the receiver state per accepted transfer and queues the command, data and
// error results it should produce. Every result transfer is matched against
// the oldest queued one. Directed frames cover the length, stop and parity
// errors; random frames, mostly well formed, run under several register settings
// with random idling on both sides and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_xor_parity_packet_deframer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 10;
  localparam int FRAME_BUF   = 32;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE      = 30;

  // mirror of the deframer: registers, frame state and pending results
  class frame_tracker;
    logic [7:0]           start_val;
    logic [7:0]           stop_val;
    logic [7:0]           timeout_val;
    xpdfr_pkg::phase_t    phase;
    logic [7:0]           frame_len;
    logic [7:0]           body_idx;
    logic [7:0]           parity;
    logic [7:0]           wait_cnt;
    logic [7:0]           body [FRAME_BUF];
    xpdfr_pkg::out_item_t results_due [$];
    int                   errors;

    function new();
      start_val   = 8'h00;
      stop_val    = 8'hFF;
      timeout_val = 8'd10;
      phase       = xpdfr_pkg::PH_HUNT;
      frame_len   = '0;
      body_idx    = '0;
      parity      = '0;
      wait_cnt    = '0;
      errors      = 0;
    endfunction

    function void set_reg(logic [1:0] addr, logic [7:0] val);
      case (addr)
        xpdfr_pkg::CFG_START:   start_val = val;
        xpdfr_pkg::CFG_STOP:    stop_val = val;
        xpdfr_pkg::CFG_TIMEOUT: timeout_val = val;
        default: ;
      endcase
    endfunction

    // queue one error report and go back to hunting
    function void raise_error(logic [1:0] code);
      xpdfr_pkg::out_item_t r;
      r.kind       = xpdfr_pkg::KIND_ERR;
      r.byte_value = '0;
      r.error_code = code;
      r.last       = 1'b1;
      results_due.push_back(r);
      phase    = xpdfr_pkg::PH_HUNT;
      body_idx = '0;
      wait_cnt = '0;
    endfunction

    // advance the frame state by one accepted transfer
    function void decode_item(xpdfr_pkg::in_item_t it);
      xpdfr_pkg::out_item_t r;
      int                   n;
      logic [7:0]           b;
      b = it.rx_byte;
      // tick: count toward timeout outside hunting
      if (it.func == xpdfr_pkg::FUNC_TICK) begin
        if (phase == xpdfr_pkg::PH_HUNT) return;
        if (int'(wait_cnt) + 1 >= int'(timeout_val)) begin
          raise_error(xpdfr_pkg::ERR_TIMEOUT);
          return;
        end
        wait_cnt = wait_cnt + 8'd1;
        return;
      end
      if (phase == xpdfr_pkg::PH_HUNT) begin
        if (b == start_val) begin
          phase    = xpdfr_pkg::PH_LEN;
          wait_cnt = '0;
        end
        return;
      end
      wait_cnt = '0;
      // length byte
      if (phase == xpdfr_pkg::PH_LEN) begin
        if (b < 8'd3 || int'(b) > FRAME_BUF - 2) begin
          raise_error(xpdfr_pkg::ERR_LENGTH);
          return;
        end
        frame_len = b;
        parity    = b;
        body_idx  = '0;
        phase     = xpdfr_pkg::PH_BODY;
        return;
      end
      // body byte
      if (int'(body_idx) < FRAME_BUF) body[body_idx] = b;
      if (int'(body_idx) + 2 < int'(frame_len)) parity = parity ^ b;
      body_idx = body_idx + 8'd1;
      if (body_idx < frame_len) return;
      if (b != stop_val) begin
        raise_error(xpdfr_pkg::ERR_STOP);
        return;
      end
      if (body[frame_len - 8'd2] != parity) begin
        raise_error(xpdfr_pkg::ERR_PARITY);
        return;
      end
      // good frame: command then data bytes
      n = int'(frame_len) - 2;
      for (int i = 0; i < n; i++) begin
        r.kind       = (i == 0) ? xpdfr_pkg::KIND_CMD : xpdfr_pkg::KIND_DATA;
        r.byte_value = body[i];
        r.error_code = '0;
        r.last       = (i == n - 1);
        results_due.push_back(r);
      end
      phase    = xpdfr_pkg::PH_HUNT;
      body_idx = '0;
      wait_cnt = '0;
    endfunction

    function void match_result(xpdfr_pkg::out_item_t got);
      xpdfr_pkg::out_item_t want;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d byte=%02h code=%0d last=%0b",
                 $time, got.kind, got.byte_value, got.error_code, got.last);
        return;
      end
      want = results_due.pop_front();
      if (got.kind !== want.kind || got.byte_value !== want.byte_value ||
          got.error_code !== want.error_code || got.last !== want.last) begin
        errors++;
        $display("%0t: mismatch expected kind=%0d byte=%02h code=%0d last=%0b",
                 $time, want.kind, want.byte_value, want.error_code, want.last);
        $display("%0t:            actual kind=%0d byte=%02h code=%0d last=%0b",
                 $time, got.kind, got.byte_value, got.error_code, got.last);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  xpdfr_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  xpdfr_pkg::out_item_t out_data;
  logic                 cfg_we;
  logic [1:0]           cfg_addr;
  logic [7:0]           cfg_wdata;

  bit idle_en;
  bit hold_req;
  int items_sent;
  int quiet_cycles;

  frame_tracker trk = new();

  xor_parity_packet_deframer_unit #(
    .FRAME_BUFFER(FRAME_BUF)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // transfer monitors
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) trk.decode_item(in_data);
    if (rst_n && out_valid && !out_stall) trk.match_result(out_data);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stall, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= idle_en && ($urandom_range(0, 99) < 6);
      end
    end
  end

  // offer one item, wait for its transfer
  task automatic send_item(input logic f, input logic [7:0] b);
    xpdfr_pkg::in_item_t it;
    it.func    = f;
    it.rx_byte = b;
    if (idle_en) begin
      while ($urandom_range(0, 99) < 6) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    trk.set_reg(addr, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // drain all pending results, then let the block finish its last item
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (trk.results_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // a few ticks that stay below the timeout
  task automatic maybe_ticks();
    int k;
    if (trk.timeout_val >= 2 && $urandom_range(0, 99) < 15) begin
      k = int'($urandom_range(1, (trk.timeout_val > 4) ? 3 : int'(trk.timeout_val) - 1));
      repeat (k) send_item(xpdfr_pkg::FUNC_TICK, 8'($urandom_range(0, 255)));
    end
  endtask

  // shortest frame: length three, command only
  task automatic send_short_frame(input logic [7:0] cmd, input logic [7:0] par,
                                  input logic [7:0] stop_b);
    send_item(xpdfr_pkg::FUNC_BYTE, trk.start_val);
    send_item(xpdfr_pkg::FUNC_BYTE, 8'd3);
    send_item(xpdfr_pkg::FUNC_BYTE, cmd);
    send_item(xpdfr_pkg::FUNC_BYTE, par);
    send_item(xpdfr_pkg::FUNC_BYTE, stop_b);
  endtask

  // one random frame, mostly well formed
  task automatic send_frame();
    logic [7:0] len;
    logic [7:0] par;
    logic [7:0] d;
    int         r;
    int         flaw;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // line noise
      repeat ($urandom_range(1, 4)) begin
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end else if (r < 18) begin
      // out of range length
      send_item(xpdfr_pkg::FUNC_BYTE, trk.start_val);
      if ($urandom_range(0, 1)) len = 8'($urandom_range(0, 2));
      else len = 8'($urandom_range(FRAME_BUF - 1, 255));
      send_item(xpdfr_pkg::FUNC_BYTE, len);
    end else if (r < 26) begin
      // silence after the start byte
      send_item(xpdfr_pkg::FUNC_BYTE, trk.start_val);
      if (trk.timeout_val <= 20 || $urandom_range(0, 3) == 0) begin
        repeat (trk.timeout_val) begin
          send_item(xpdfr_pkg::FUNC_TICK, 8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 10)) begin
          send_item(xpdfr_pkg::FUNC_TICK, 8'($urandom_range(0, 255)));
        end
      end
    end else begin
      // length, command, data, parity, stop
      r = $urandom_range(0, 99);
      if (r < 10) len = 8'(FRAME_BUF - 2);
      else if (r < 25) len = 8'($urandom_range(3, FRAME_BUF - 2));
      else len = 8'($urandom_range(3, 8));
      flaw = $urandom_range(0, 99);
      par  = len;
      send_item(xpdfr_pkg::FUNC_BYTE, trk.start_val);
      maybe_ticks();
      send_item(xpdfr_pkg::FUNC_BYTE, len);
      for (int i = 0; i < int'(len) - 2; i++) begin
        d   = 8'($urandom_range(0, 255));
        par = par ^ d;
        maybe_ticks();
        send_item(xpdfr_pkg::FUNC_BYTE, d);
      end
      // timeout in the middle of the body
      if (flaw >= 16 && flaw < 20 && trk.timeout_val <= 20) begin
        repeat (trk.timeout_val) begin
          send_item(xpdfr_pkg::FUNC_TICK, 8'($urandom_range(0, 255)));
        end
        return;
      end
      maybe_ticks();
      send_item(xpdfr_pkg::FUNC_BYTE, (flaw < 8) ? par ^ 8'($urandom_range(1, 255)) : par);
      maybe_ticks();
      send_item(xpdfr_pkg::FUNC_BYTE, (flaw >= 8 && flaw < 16) ?
                trk.stop_val ^ 8'($urandom_range(1, 255)) : trk.stop_val);
    end
  endtask

  // new register setting, optional result hold-off, then random frames
  task automatic run_phase(input logic [7:0] start_b, input logic [7:0] stop_b,
                           input logic [7:0] ticks, input int count,
                           input bit hold_off);
    int target;
    settle();
    write_reg(xpdfr_pkg::CFG_START, start_b);
    write_reg(xpdfr_pkg::CFG_STOP, stop_b);
    write_reg(xpdfr_pkg::CFG_TIMEOUT, ticks);
    if (hold_off) hold_req = 1'b1;
    target = items_sent + count;
    while (items_sent < target) send_frame();
  endtask

  // stimulus
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_addr   = xpdfr_pkg::CFG_START;
    cfg_wdata  = '0;
    idle_en    = 1'b1;
    hold_req   = 1'b0;
    items_sent = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed frames at reset register values
    send_item(xpdfr_pkg::FUNC_TICK, 8'h00);
    send_item(xpdfr_pkg::FUNC_BYTE, 8'h5A);
    send_short_frame(8'hFF, 8'h03 ^ 8'hFF, 8'hFF);
    send_item(xpdfr_pkg::FUNC_BYTE, trk.start_val);
    send_item(xpdfr_pkg::FUNC_BYTE, 8'd2);
    send_item(xpdfr_pkg::FUNC_BYTE, trk.start_val);
    send_item(xpdfr_pkg::FUNC_BYTE, 8'd31);
    send_item(xpdfr_pkg::FUNC_BYTE, trk.start_val);
    send_item(xpdfr_pkg::FUNC_BYTE, 8'hFF);
    send_short_frame(8'h00, 8'h03, 8'h7F);
    send_short_frame(8'h81, 8'h00, 8'hFF);

    // random frames under several register settings
    run_phase(8'h00, 8'hFF, 8'd10, 100, 1'b0);
    run_phase(8'hA5, 8'h5A, 8'd1, 110, 1'b0);
    run_phase(8'hFF, 8'h00, 8'd255, 110, 1'b1);
    idle_en = 1'b0;
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(2, 16)), 110, 1'b0);
    idle_en = 1'b1;

    settle();
    if (trk.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
